[src/lru_pr_pkg.sv]
package lru_pr_pkg;

    localparam int FRAMES_DEF    = 8;
    localparam int PAGE_BITS_DEF = 16;

    localparam int CFG_W       = 4;
    localparam int FRAME_IDX_W = 3;
    localparam int FAULT_W     = 32;

    localparam logic [CFG_W-1:0]   CFG_RESET = 4'd8;
    localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

    localparam int STATE_W = 2;
    localparam logic [STATE_W-1:0] ST_IDLE   = 2'd0;
    localparam logic [STATE_W-1:0] ST_SCAN   = 2'd1;
    localparam logic [STATE_W-1:0] ST_UPDATE = 2'd2;

endpackage

[src/lru_pr_req_if.sv]
interface lru_pr_req_if #(
    parameter int PAGE_BITS = lru_pr_pkg::PAGE_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [PAGE_BITS-1:0] page_number;

    modport source (output valid, output page_number, input ready);
    modport sink   (input valid, input page_number, output ready);
endinterface

[src/lru_pr_rsp_if.sv]
interface lru_pr_rsp_if #(
    parameter int PAGE_BITS = lru_pr_pkg::PAGE_BITS_DEF
);
    logic                                  valid;
    logic                                  ready;
    logic                                  hit;
    logic [lru_pr_pkg::FRAME_IDX_W-1:0]    frame_index;
    logic                                  evicted_valid;
    logic [PAGE_BITS-1:0]                  evicted_page;
    logic [lru_pr_pkg::FAULT_W-1:0]        fault_count;

    modport source (output valid, output hit, output frame_index, output evicted_valid,
                    output evicted_page, output fault_count, input ready);
    modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                    input evicted_page, input fault_count, output ready);
endinterface

[src/lru_pr_cell.sv]
module lru_pr_cell #(
    parameter int FRAMES    = lru_pr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lru_pr_pkg::PAGE_BITS_DEF,
    parameter int IDX       = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [lru_pr_pkg::CFG_W-1:0]  cfg,
    input  logic [(FRAMES > 1 ? $clog2(FRAMES) : 1)*5 + PAGE_BITS*2 + 2 - 1:0] rec_in,
    output logic [(FRAMES > 1 ? $clog2(FRAMES) : 1)*5 + PAGE_BITS*2 + 2 - 1:0] rec_out,
    input  logic [(FRAMES > 1 ? $clog2(FRAMES) : 1)*2 + PAGE_BITS + 3 - 1:0]   upd_in
);

    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    typedef struct packed {
        logic                 found;
        logic [IW-1:0]        hit_idx;
        logic [IW-1:0]        hit_rank;
        logic                 free_found;
        logic [IW-1:0]        free_idx;
        logic [IW-1:0]        best_idx;
        logic [IW-1:0]        best_rank;
        logic [PAGE_BITS-1:0] best_page;
        logic [PAGE_BITS-1:0] page;
    } search_t;

    typedef struct packed {
        logic                 en;
        logic                 load;
        logic                 age_all;
        logic [IW-1:0]        idx;
        logic [IW-1:0]        limit;
        logic [PAGE_BITS-1:0] page;
    } update_t;

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    search_t              rin;
    search_t              rec_next;
    search_t              rec_out_reg;
    update_t              upd;
    logic                 active;
    logic                 valid_reg;
    logic [PAGE_BITS-1:0] page_reg;
    logic [IW-1:0]        rank_reg;

    assign rin     = rec_in;
    assign upd     = upd_in;
    assign rec_out = rec_out_reg;
    assign active  = (IDX == 0) || (IDX < int'(cfg));

    always_comb
    begin
        rec_next = rin;
        if (active && valid_reg && page_reg == rin.page && !rin.found)
        begin
            rec_next.found    = 1'b1;
            rec_next.hit_idx  = MY_IDX;
            rec_next.hit_rank = rank_reg;
        end
        if (active && !valid_reg && !rin.free_found)
        begin
            rec_next.free_found = 1'b1;
            rec_next.free_idx   = MY_IDX;
        end
        if (active && (IDX == 0 || (valid_reg && rank_reg > rin.best_rank)))
        begin
            rec_next.best_idx  = MY_IDX;
            rec_next.best_rank = rank_reg;
            rec_next.best_page = page_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_out_reg <= rec_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (upd.en && upd.load && upd.idx == MY_IDX)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd.en)
        begin
            if (upd.idx == MY_IDX)
            begin
                rank_reg <= '0;
                if (upd.load)
                begin
                    page_reg <= upd.page;
                end
            end
            else if (valid_reg && (upd.age_all || rank_reg < upd.limit))
            begin
                rank_reg <= rank_reg + 1'b1;
            end
        end
    end

endmodule

[src/lru_page_replacement_top.sv]
// Channel  Role     Handshake     Payload
// req      sink     valid/ready   page_number
// rsp      source   valid/ready   hit, frame_index, evicted_valid, evicted_page, fault_count
// cfg      write    cfg_wr_en     cfg_wr_data (frames_in_use)
//
// A reference is captured, then its search record passes down the chain of frame cells,
// and then the update is committed.
// rst_n clears all frames to empty, the fault count to zero and frames_in_use to 8.
// A result waits in the output register; the update stalls while it is not taken.
module lru_page_replacement_top #(
    parameter int FRAMES    = lru_pr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lru_pr_pkg::PAGE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [lru_pr_pkg::CFG_W-1:0]  cfg_wr_data,
    lru_pr_req_if.sink                    req,
    lru_pr_rsp_if.source                  rsp
);

    localparam int IW    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int REC_W = IW * 5 + PAGE_BITS * 2 + 2;
    localparam int UPD_W = IW * 2 + PAGE_BITS + 3;
    localparam logic [IW-1:0] LAST_CNT = IW'(FRAMES - 1);

    typedef struct packed {
        logic                 found;
        logic [IW-1:0]        hit_idx;
        logic [IW-1:0]        hit_rank;
        logic                 free_found;
        logic [IW-1:0]        free_idx;
        logic [IW-1:0]        best_idx;
        logic [IW-1:0]        best_rank;
        logic [PAGE_BITS-1:0] best_page;
        logic [PAGE_BITS-1:0] page;
    } search_t;

    typedef struct packed {
        logic                 en;
        logic                 load;
        logic                 age_all;
        logic [IW-1:0]        idx;
        logic [IW-1:0]        limit;
        logic [PAGE_BITS-1:0] page;
    } update_t;

    logic [lru_pr_pkg::CFG_W-1:0]   cfg_reg;
    logic [lru_pr_pkg::STATE_W-1:0] state_reg;
    logic [lru_pr_pkg::STATE_W-1:0] state_next;
    logic [IW-1:0]                  cnt_reg;
    search_t                        seed_reg;
    search_t                        seed_next;
    logic [REC_W-1:0]               chain [FRAMES+1];
    search_t                        fin;
    update_t                        upd;
    logic                           commit;
    logic                           evict;
    logic [lru_pr_pkg::FAULT_W-1:0] fault_reg;
    logic [lru_pr_pkg::FAULT_W-1:0] fault_next;

    logic                                  out_valid_reg;
    logic                                  out_hit_reg;
    logic [lru_pr_pkg::FRAME_IDX_W-1:0]    out_idx_reg;
    logic                                  out_ev_valid_reg;
    logic [PAGE_BITS-1:0]                  out_ev_page_reg;
    logic [lru_pr_pkg::FAULT_W-1:0]        out_fault_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= lru_pr_pkg::CFG_RESET;
        end
        else if (cfg_wr_en)
        begin
            cfg_reg <= cfg_wr_data;
        end
    end

    assign req.ready = (state_reg == lru_pr_pkg::ST_IDLE);
    assign commit    = (state_reg == lru_pr_pkg::ST_UPDATE) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lru_pr_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = lru_pr_pkg::ST_SCAN;
                end
            end
            lru_pr_pkg::ST_SCAN:
            begin
                if (cnt_reg == LAST_CNT)
                begin
                    state_next = lru_pr_pkg::ST_UPDATE;
                end
            end
            lru_pr_pkg::ST_UPDATE:
            begin
                if (commit)
                begin
                    state_next = lru_pr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lru_pr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lru_pr_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == lru_pr_pkg::ST_SCAN && cnt_reg != LAST_CNT)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else
            begin
                cnt_reg <= '0;
            end
        end
    end

    always_comb
    begin
        seed_next      = '0;
        seed_next.page = req.page_number;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            seed_reg <= seed_next;
        end
    end

    assign chain[0] = seed_reg;

    for (genvar g = 0; g < FRAMES; g++)
    begin : g_cell
        lru_pr_cell #(
            .FRAMES    (FRAMES),
            .PAGE_BITS (PAGE_BITS),
            .IDX       (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .cfg     (cfg_reg),
            .rec_in  (chain[g]),
            .rec_out (chain[g+1]),
            .upd_in  (UPD_W'(upd))
        );
    end

    assign fin   = chain[FRAMES];
    assign evict = !fin.found && !fin.free_found;

    always_comb
    begin
        upd         = '0;
        upd.en      = commit;
        upd.load    = !fin.found;
        upd.page    = fin.page;
        if (fin.found)
        begin
            upd.idx   = fin.hit_idx;
            upd.limit = fin.hit_rank;
        end
        else if (fin.free_found)
        begin
            upd.idx     = fin.free_idx;
            upd.age_all = 1'b1;
        end
        else
        begin
            upd.idx   = fin.best_idx;
            upd.limit = fin.best_rank;
        end
    end

    always_comb
    begin
        fault_next = fault_reg;
        if (!fin.found && fault_reg != lru_pr_pkg::FAULT_MAX)
        begin
            fault_next = fault_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fault_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (commit)
        begin
            fault_reg     <= fault_next;
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_hit_reg      <= fin.found;
            out_idx_reg      <= lru_pr_pkg::FRAME_IDX_W'(upd.idx);
            out_ev_valid_reg <= evict;
            out_ev_page_reg  <= evict ? fin.best_page : '0;
            out_fault_reg    <= fault_next;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.hit           = out_hit_reg;
    assign rsp.frame_index   = out_idx_reg;
    assign rsp.evicted_valid = out_ev_valid_reg;
    assign rsp.evicted_page  = out_ev_page_reg;
    assign rsp.fault_count   = out_fault_reg;

`ifndef NO_ASSERTIONS
    a_out_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == lru_pr_pkg::ST_UPDATE))
        else $error("result raised without an update commit");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_hit_reg && out_ev_valid_reg))
        else $error("hit reported together with an eviction");

    a_fault_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        fault_reg >= $past(fault_reg))
        else $error("fault count decreased");

    a_miss_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && !fin.found && fault_reg != lru_pr_pkg::FAULT_MAX)
        |=> fault_reg == $past(fault_reg) + 1'b1)
        else $error("miss did not advance fault count");
`endif

endmodule

[verif/tb_lru_page_replacement_top.sv]
`timescale 1ns / 100ps

module tb_lru_page_replacement_top;

    import lru_pr_pkg::*;

    localparam int FRAMES    = FRAMES_DEF;
    localparam int PAGE_BITS = PAGE_BITS_DEF;
    localparam int PHASES    = 12;
    localparam int PHASE_REFS = 70;

    typedef struct packed {
        logic                   hit;
        logic [FRAME_IDX_W-1:0] frame_index;
        logic                   evicted_valid;
        logic [PAGE_BITS-1:0]   evicted_page;
        logic [FAULT_W-1:0]     fault_count;
    } lru_result_t;

    class lru_fault_scoreboard;
        logic [CFG_W-1:0]     frames_reg;
        bit                   slot_used [FRAMES];
        logic [PAGE_BITS-1:0] slot_page [FRAMES];
        int unsigned          slot_age [FRAMES];
        logic [FAULT_W-1:0]   faults;
        lru_result_t          expected_q[$];
        int unsigned          errors;
        int unsigned          results_seen;

        function new();
            int i;
            frames_reg = CFG_RESET;
            for (i = 0; i < FRAMES; i++)
            begin
                slot_used[i] = 1'b0;
                slot_page[i] = '0;
                slot_age[i]  = 0;
            end
            faults       = '0;
            errors       = 0;
            results_seen = 0;
        endfunction

        function void set_frames(logic [CFG_W-1:0] v);
            frames_reg = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void make_recent(int f, int unsigned limit);
            int i;
            for (i = 0; i < FRAMES; i++)
            begin
                if (i != f && slot_used[i] && slot_age[i] < limit)
                    slot_age[i]++;
            end
            slot_age[f] = 0;
        endfunction

        function void note_request(logic [PAGE_BITS-1:0] pg);
            int          n;
            int          f;
            int          i;
            bit          found;
            bit          free_found;
            lru_result_t r;
            n = int'(frames_reg);
            if (n < 1)
                n = 1;
            if (n > FRAMES)
                n = FRAMES;
            f = 0;
            found = 1'b0;
            free_found = 1'b0;
            r = '0;
            for (i = 0; i < n && !found; i++)
            begin
                if (slot_used[i] && slot_page[i] == pg)
                begin
                    f = i;
                    found = 1'b1;
                end
            end
            if (found)
            begin
                make_recent(f, slot_age[f]);
            end
            else
            begin
                if (faults != FAULT_MAX)
                    faults++;
                for (i = 0; i < n && !free_found; i++)
                begin
                    if (!slot_used[i])
                    begin
                        f = i;
                        free_found = 1'b1;
                    end
                end
                if (free_found)
                begin
                    make_recent(f, FRAMES);
                end
                else
                begin
                    f = 0;
                    for (i = 1; i < n; i++)
                    begin
                        if (slot_age[i] > slot_age[f])
                            f = i;
                    end
                    r.evicted_valid = 1'b1;
                    r.evicted_page  = slot_page[f];
                    make_recent(f, slot_age[f]);
                end
                slot_used[f] = 1'b1;
                slot_page[f] = pg;
            end
            r.hit         = found;
            r.frame_index = f[FRAME_IDX_W-1:0];
            r.fault_count = faults;
            expected_q.push_back(r);
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 100)
                $display("[%0t] mismatch on result %0d: %s", $time, results_seen, msg);
        endtask

        task check_result(lru_result_t got);
            lru_result_t want;
            results_seen++;
            if (expected_q.size() == 0)
            begin
                report_mismatch("result transfer with no reference pending");
                return;
            end
            want = expected_q.pop_front();
            if (got.hit !== want.hit)
                report_mismatch($sformatf("hit got %0b want %0b", got.hit, want.hit));
            if (got.frame_index !== want.frame_index)
                report_mismatch($sformatf("frame_index got %0d want %0d",
                                          got.frame_index, want.frame_index));
            if (got.evicted_valid !== want.evicted_valid)
                report_mismatch($sformatf("evicted_valid got %0b want %0b",
                                          got.evicted_valid, want.evicted_valid));
            if (got.evicted_page !== want.evicted_page)
                report_mismatch($sformatf("evicted_page got %h want %h",
                                          got.evicted_page, want.evicted_page));
            if (got.fault_count !== want.fault_count)
                report_mismatch($sformatf("fault_count got %0d want %0d",
                                          got.fault_count, want.fault_count));
        endtask
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;
    bit               idle_tx;
    bit               stall_rx;

    lru_fault_scoreboard sb;

    lru_pr_req_if #(.PAGE_BITS(PAGE_BITS)) req_ch ();
    lru_pr_rsp_if #(.PAGE_BITS(PAGE_BITS)) rsp_ch ();

    lru_page_replacement_top #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        rsp_ch.ready <= !(stall_rx && $urandom_range(99) < 71);
    end

    always @(posedge clk)
    begin : watch_transfers
        lru_result_t got;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.hit           = rsp_ch.hit;
                got.frame_index   = rsp_ch.frame_index;
                got.evicted_valid = rsp_ch.evicted_valid;
                got.evicted_page  = rsp_ch.evicted_page;
                got.fault_count   = rsp_ch.fault_count;
                sb.check_result(got);
            end
            if (req_ch.valid && req_ch.ready)
                sb.note_request(req_ch.page_number);
        end
    end

    task automatic send_page(input logic [PAGE_BITS-1:0] pg);
        if (idle_tx)
        begin
            while ($urandom_range(99) < 71)
            begin
                req_ch.valid <= 1'b0;
                @(posedge clk);
            end
        end
        req_ch.valid       <= 1'b1;
        req_ch.page_number <= pg;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic set_frames(input logic [CFG_W-1:0] v);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_frames(v);
    endtask

    task automatic send_list(input logic [PAGE_BITS-1:0] pages[$]);
        foreach (pages[k])
            send_page(pages[k]);
    endtask

    initial
    begin
        #8ms;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        logic [CFG_W-1:0]     phase_cfg [PHASES];
        logic [PAGE_BITS-1:0] pool [$];
        logic [PAGE_BITS-1:0] pg;
        int                   pool_size;
        int                   sel;
        sb = new();
        phase_cfg = '{4'd3, 4'd8, 4'd1, 4'd15, 4'd0, 4'd6, 4'd2, 4'd12, 4'd7, 4'd5,
                      4'd4, 4'd8};
        rst_n              <= 1'b0;
        cfg_wr_en          <= 1'b0;
        cfg_wr_data        <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.page_number <= '0;
        idle_tx  = 1'b0;
        stall_rx = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset frame count, fill all frames, then evict
        send_list('{16'h0000, 16'hFFFF, 16'h0000, 16'h0001, 16'h0002, 16'h0003,
                    16'h0004, 16'h0005, 16'h0006, 16'h0007, 16'hFFFF});
        // shrink: page 3 stays in an inactive frame and faults again
        set_frames(4'd2);
        send_list('{16'h0003, 16'hAAAA});
        // grow: page 3 now resident twice
        set_frames(4'd8);
        send_list('{16'h0003, 16'h5555});
        set_frames(4'd0);
        send_list('{16'h1234, 16'h1234, 16'h4321});
        set_frames(4'd15);
        send_list('{16'h8000, 16'h4321});

        for (int p = 0; p < PHASES; p++)
        begin
            set_frames(phase_cfg[p]);
            idle_tx  = (p % 4 == 1) || (p % 4 == 3);
            stall_rx = (p % 4 == 2) || (p % 4 == 3);
            pool_size = $urandom_range(12, 1);
            pool.delete();
            repeat (pool_size)
                pool.push_back(PAGE_BITS'($urandom));
            repeat (PHASE_REFS)
            begin
                sel = $urandom_range(99);
                if (sel < 80)
                    pg = pool[$urandom_range(pool_size - 1)];
                else if (sel < 90)
                    pg = PAGE_BITS'($urandom);
                else if (sel < 95)
                    pg = '0;
                else
                    pg = '1;
                send_page(pg);
            end
        end

        drain_results();
        stall_rx = 1'b0;
        repeat (FRAMES + 4) @(posedge clk);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[filelist.f]
src/lru_pr_pkg.sv
src/lru_pr_req_if.sv
src/lru_pr_rsp_if.sv
src/lru_pr_cell.sv
src/lru_page_replacement_top.sv
verif/tb_lru_page_replacement_top.sv
